>>> hw/rtl/ncmh_pkg.sv
// Shared types, codes and constants for the nearest color match block.
// Used by the controller, the datapath and the top level.
package ncmh_pkg;

	localparam int unsigned DEF_PALETTE_DEPTH = 256;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned COLOR_W = 3 * CH_W;
	localparam int unsigned DIST_W = 18;
	localparam int unsigned CFG_W  = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CNT_W  = 9;

	localparam logic [CFG_W-1:0] TOLERANCE_RST  = 9'd20;
	localparam logic [CFG_W-1:0] HYSTERESIS_RST = 9'd5;

	// input item action codes
	localparam logic ACT_LOAD     = 1'b0;
	localparam logic ACT_CLASSIFY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 2'd2;

	typedef struct packed {
		logic load;     // palette write transfer
		logic capture;  // classify transfer, latch sample
		logic prep;     // set up walk: squares, count, clear best
		logic issue;    // read one palette entry
		logic decide;   // update held match, load output register
	} ncmh_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic pipe_busy;
		logic out_free;
	} ncmh_stat_t;

	function automatic logic [DIST_W-1:0] sq_dist(input logic [COLOR_W-1:0] c1,
			input logic [COLOR_W-1:0] c2);
		logic [CH_W-1:0] x;
		logic [CH_W-1:0] y;
		logic [CH_W-1:0] d;
		logic [DIST_W-1:0] s;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			x = c1[k*CH_W +: CH_W];
			y = c2[k*CH_W +: CH_W];
			d = (x > y) ? x - y : y - x;
			s = s + DIST_W'(d) * DIST_W'(d);
		end
		return s;
	endfunction

endpackage

>>> hw/rtl/ncmh_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module ncmh_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/ncmh_ctrl.sv
// Sequencing state machine for the nearest color match block.
// Depends on ncmh_pkg; drives ncmh_dp through command and status structs.
module ncmh_ctrl
	import ncmh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       action,
	output logic       in_stall,
	output ncmh_cmd_t  cmd,
	input  ncmh_stat_t stat
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PREP   = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_DECIDE = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_CLASSIFY) begin
						cmd.capture = 1'b1;
						state_nxt = ST_PREP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_done)
					state_nxt = ST_DRAIN;
				else
					cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy)
					state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				// hold until the previous result has been taken
				if (stat.out_free) begin
					cmd.decide = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/ncmh_dp.sv
// Datapath: palette RAM, walk counter, distance pipeline, best-match tracking,
// held match state, config registers and output register. Uses ncmh_pkg, ncmh_ram.
module ncmh_dp
	import ncmh_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ncmh_cmd_t            cmd,
	output ncmh_stat_t           stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [CH_W-1:0]      entry_index,
	input  logic [CH_W-1:0]      l_value,
	input  logic [CH_W-1:0]      a_value,
	input  logic [CH_W-1:0]      b_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [CH_W-1:0]      color_index,
	output logic [DIST_W-1:0]    distance_sq,
	output logic                 updated,
	output logic [CH_W-1:0]      held_l,
	output logic [CH_W-1:0]      held_a,
	output logic [CH_W-1:0]      held_b
);

	localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] WALK_MAX =
		CNT_W'((PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256);
	localparam logic [12:0] DEPTH_LIM = 13'(PALETTE_DEPTH);

	logic [CFG_W-1:0] psize_q, tol_q, hyst_q;
	logic [COLOR_W-1:0] in_color, sample_q, rdata;
	logic [CNT_W-1:0] cnt_q, count_q;
	logic [DIST_W-1:0] tol_sq_q, hyst_sq_q, hyst_dist_q;
	logic v_s1, v_s2;
	logic [CH_W-1:0] idx_s1, idx_s2;
	logic [DIST_W-1:0] dist_s2;
	logic hit_q;
	logic [CH_W-1:0] best_i_q;
	logic [DIST_W-1:0] best_d_q;
	logic [COLOR_W-1:0] held_color_q;
	logic [CH_W-1:0] held_index_q;
	logic [DIST_W-1:0] held_dist_q;
	logic match_valid_q;
	logic out_valid_q;
	logic load_ok, keep, take;

	assign in_color = {b_value, a_value, l_value};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= '0;
			tol_q   <= TOLERANCE_RST;
			hyst_q  <= HYSTERESIS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PALETTE_SIZE: psize_q <= cfg_data;
				REG_TOLERANCE:    tol_q   <= cfg_data;
				REG_HYSTERESIS:   hyst_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// loads past PALETTE_DEPTH are dropped
	assign load_ok = cmd.load && ({5'b0, entry_index} < DEPTH_LIM);

	ncmh_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (load_ok),
		.waddr(AW'(entry_index)),
		.wdata(in_color),
		.raddr(AW'(cnt_q)),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture)
			sample_q <= in_color;
		if (cmd.prep) begin
			tol_sq_q    <= DIST_W'(tol_q * tol_q);
			hyst_sq_q   <= DIST_W'(hyst_q * hyst_q);
			hyst_dist_q <= sq_dist(held_color_q, sample_q);
			count_q     <= (psize_q > WALK_MAX) ? WALK_MAX : psize_q;
		end
		idx_s1  <= cnt_q[CH_W-1:0];
		idx_s2  <= idx_s1;
		dist_s2 <= sq_dist(rdata, sample_q);
	end

	// walk counter and read pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cmd.prep)
				cnt_q <= '0;
			else if (cmd.issue)
				cnt_q <= cnt_q + 1'b1;
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// first smallest distance within tolerance wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			best_i_q <= '0;
			best_d_q <= '0;
		end else if (cmd.prep) begin
			hit_q <= 1'b0;
		end else if (v_s2 && dist_s2 <= tol_sq_q && (!hit_q || dist_s2 < best_d_q)) begin
			hit_q    <= 1'b1;
			best_i_q <= idx_s2;
			best_d_q <= dist_s2;
		end
	end

	assign keep = match_valid_q && (hyst_dist_q < hyst_sq_q);
	assign take = hit_q && !keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_color_q  <= '0;
			held_index_q  <= '0;
			held_dist_q   <= '0;
			match_valid_q <= 1'b0;
		end else if (cmd.decide) begin
			if (take) begin
				held_color_q <= sample_q;
				held_index_q <= best_i_q;
				held_dist_q  <= best_d_q;
			end
			match_valid_q <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.decide)
			out_valid_q <= 1'b1;
		else if (out_valid_q && !out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			found   <= hit_q;
			updated <= take;
			if (!hit_q) begin
				color_index <= '0;
				distance_sq <= '0;
				held_l      <= '0;
				held_a      <= '0;
				held_b      <= '0;
			end else if (take) begin
				color_index <= best_i_q;
				distance_sq <= best_d_q;
				held_l      <= sample_q[0 +: CH_W];
				held_a      <= sample_q[CH_W +: CH_W];
				held_b      <= sample_q[2*CH_W +: CH_W];
			end else begin
				color_index <= held_index_q;
				distance_sq <= held_dist_q;
				held_l      <= held_color_q[0 +: CH_W];
				held_a      <= held_color_q[CH_W +: CH_W];
				held_b      <= held_color_q[2*CH_W +: CH_W];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.walk_done = (cnt_q == count_q);
	assign stat.pipe_busy = v_s1 || v_s2;
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

>>> hw/rtl/nearest_color_match_hysteresis.sv
// Nearest palette color match (squared CIE76 distance) with hysteresis.
// Top level: ncmh_ctrl state machine plus ncmh_dp datapath; uses ncmh_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall): action = load writes one palette entry
//   at entry_index and gives no result. action = classify walks
//   entries 0 .. min(palette_size, PALETTE_DEPTH, 256) - 1 and yields one
//   result on the output channel (out_valid/out_stall).
//   Config channel (cfg_valid/cfg_ready, cfg_ready always high): index 0
//   palette_size, 1 tolerance, 2 hysteresis; other indexes are ignored.
//   Write it only while the block is idle.
//   During a walk one palette RAM read is issued per cycle.
//   in_stall stays high until the result is registered; while the block is
//   idle, loads can be taken one per cycle.
//   The output register holds a result until its transfer; a pending result
//   does not block loads or the next walk, only the final update step waits.
//   Reset: palette_size 0, tolerance 20, hysteresis 5, no held match. The
//   palette RAM is not cleared; entries must be loaded before use.
module nearest_color_match_hysteresis
	import ncmh_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [CH_W-1:0]      entry_index,
	input  logic [CH_W-1:0]      l_value,
	input  logic [CH_W-1:0]      a_value,
	input  logic [CH_W-1:0]      b_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [CH_W-1:0]      color_index,
	output logic [DIST_W-1:0]    distance_sq,
	output logic                 updated,
	output logic [CH_W-1:0]      held_l,
	output logic [CH_W-1:0]      held_a,
	output logic [CH_W-1:0]      held_b,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ncmh_cmd_t  cmd;
	ncmh_stat_t stat;

	assign cfg_ready = 1'b1;

	ncmh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (action),
		.in_stall(in_stall),
		.cmd     (cmd),
		.stat    (stat)
	);

	ncmh_dp #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.entry_index(entry_index),
		.l_value    (l_value),
		.a_value    (a_value),
		.b_value    (b_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.color_index(color_index),
		.distance_sq(distance_sq),
		.updated    (updated),
		.held_l     (held_l),
		.held_a     (held_a),
		.held_b     (held_b)
	);

`ifndef SYNTHESIS
	// a classify transfer starts a walk, so the input side must stall next
	a_classify_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action == ACT_CLASSIFY) |=> in_stall)
		else $error("input not stalled after classify transfer");

	a_update_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && updated) |-> found)
		else $error("update reported without a match");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (color_index == 0 && distance_sq == 0 &&
			held_l == 0 && held_a == 0 && held_b == 0))
		else $error("no-match result carries nonzero payload");

	a_no_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !in_stall) |=> !out_valid)
		else $error("result appeared without a walk");
`endif

endmodule
